// ===== rtl/dre_pkg.sv =====
`timescale 1ns / 1ps
// Package for the debounced rotary encoder event decoder.
// Holds shared constants, event codes and the result type; no dependencies.
package dre_pkg;

  // Default width of the free-running tick counter
  localparam int TICK_WIDTH_DEF = 32;

  // Configuration register widths, indexes and reset values
  localparam int STABLE_W = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = STABLE_W;
  localparam logic [CFG_INDEX_W-1:0] REG_STABLE_TICKS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_EVENTS_ENABLED = 2'd1;
  localparam logic [STABLE_W-1:0] STABLE_TICKS_RST = 16'd10;
  localparam logic EVENTS_ENABLED_RST = 1'b1;

  // Packed pin code: bit 2 button pressed, bit 1 A high, bit 0 B active
  localparam int CODE_W = 3;
  localparam int CODE_BUTTON_BIT = 2;
  localparam int CODE_A_BIT = 1;
  localparam int CODE_B_BIT = 0;
  localparam logic [1:0] ROT_CCW = 2'b11;
  localparam logic [1:0] ROT_CW = 2'b01;

  // Event codes as they appear on the output stream
  typedef enum logic [1:0] {
    EV_PUSH    = 2'd0,
    EV_RELEASE = 2'd1,
    EV_CW      = 2'd2,
    EV_CCW     = 2'd3
  } event_t;

  // One queued result
  typedef struct packed {
    event_t code;
    logic   last;
  } result_t;

  // Result queue: room for two polls' worth of events
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

  // Output stream data width (event code padded to a byte)
  localparam int OUT_DATA_W = 8;

endpackage

// ===== rtl/debounced_rotary_encoder_events.sv =====
`timescale 1ns / 1ps
// Top level of the debounced rotary encoder and push-button event decoder.
// Depends on dre_pkg for constants, event codes and the result type.

// One poll (button, A and B pin levels plus the tick count) is taken per clock
// cycle. The poll is debounced and decoded combinationally, and the 0, 1 or
// 2 events it causes are written into a four-entry result queue in that same
// cycle; the queue drains one event per cycle on the output stream while it
// is ready, the last event of each poll flagged with tlast. The input is ready
// while the queue has room for two events, so polls are taken back to back and
// the sustained rate is one poll per cycle unless the events produced outrun
// the one event per cycle that the output side takes. A code is accepted once
// it has held for stable_ticks ticks (wrap-around difference); the first
// accepted code only primes the change detector. Config writes apply at once.
module debounced_rotary_encoder_events #(
  parameter int TICK_WIDTH = dre_pkg::TICK_WIDTH_DEF,
  localparam int IN_DATA_W = ((3 + TICK_WIDTH + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst,
  // Poll input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [0] button_level, [1] phase_a_level, [2] phase_b_level,
  // [3 +: TICK_WIDTH] tick_now, zero padding above
  input  logic [IN_DATA_W-1:0]             s_axis_tdata,
  // Event output stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [1:0] event_code, zero padding above
  output logic [dre_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                             m_axis_tlast,  // last_of_run
  // Configuration write port
  input  logic                             cfg_wr_en,
  input  logic [dre_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [dre_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CMP_W = (TICK_WIDTH > dre_pkg::STABLE_W) ? TICK_WIDTH : dre_pkg::STABLE_W;

  // Configuration registers
  logic [dre_pkg::STABLE_W-1:0] stable_ticks;
  logic                         events_enabled;

  // Debounce and decoder state
  logic [dre_pkg::CODE_W-1:0] candidate_code, candidate_code_next;
  logic [TICK_WIDTH-1:0]      candidate_since, candidate_since_next;
  logic [dre_pkg::CODE_W-1:0] accepted_code, accepted_code_next;
  logic                       accepted_valid, accepted_valid_next;
  logic                       button_held, button_held_next;
  logic                       rotation_latched, rotation_latched_next;

  // Result queue
  dre_pkg::result_t                 queue [dre_pkg::QUEUE_DEPTH];
  logic [dre_pkg::QUEUE_PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [dre_pkg::QUEUE_CNT_W-1:0]  count, count_next;

  // Decode signals
  logic                       in_xfer, out_xfer;
  logic [dre_pkg::CODE_W-1:0] code, acc_base;
  logic [TICK_WIDTH-1:0]      tick_now, elapsed;
  logic                       stable_enough;
  logic [1:0]                 rot;
  logic                       btn_ev, rot_ev, rot_armed;
  dre_pkg::event_t            btn_code, rot_code;
  dre_pkg::result_t           slot0, slot1;
  logic [1:0]                 n_ev;

  assign in_xfer  = s_axis_tvalid & s_axis_tready;
  assign out_xfer = m_axis_tvalid & m_axis_tready;

  // Pin code and elapsed ticks
  assign tick_now = s_axis_tdata[3 +: TICK_WIDTH];
  assign code = {~s_axis_tdata[0], s_axis_tdata[1], ~s_axis_tdata[2]};
  assign elapsed = tick_now - candidate_since;
  assign stable_enough = CMP_W'(elapsed) >= CMP_W'(stable_ticks);
  assign rot = code[dre_pkg::CODE_A_BIT:dre_pkg::CODE_B_BIT];

  // Debounce, change detection and event decode for one poll
  always_comb begin
    candidate_code_next   = candidate_code;
    candidate_since_next  = candidate_since;
    accepted_code_next    = accepted_code;
    accepted_valid_next   = accepted_valid;
    button_held_next      = button_held;
    rotation_latched_next = rotation_latched;
    acc_base  = accepted_valid ? accepted_code : code;
    btn_ev    = 1'b0;
    btn_code  = dre_pkg::EV_PUSH;
    rot_ev    = 1'b0;
    rot_code  = dre_pkg::EV_CW;
    rot_armed = 1'b0;
    if (code != candidate_code) begin
      candidate_code_next  = code;
      candidate_since_next = tick_now;
    end else if (stable_enough) begin
      accepted_valid_next = 1'b1;
      accepted_code_next  = code;
      if (acc_base != code && events_enabled) begin
        // Button push or release
        if (code[dre_pkg::CODE_BUTTON_BIT] && !button_held) begin
          btn_ev = 1'b1;
          btn_code = dre_pkg::EV_PUSH;
          button_held_next = 1'b1;
        end else if (!code[dre_pkg::CODE_BUTTON_BIT] && button_held) begin
          btn_ev = 1'b1;
          btn_code = dre_pkg::EV_RELEASE;
          button_held_next = 1'b0;
        end
        // Rotation, re-armed once B is released
        rot_armed = rotation_latched;
        if (!rotation_latched) begin
          if (rot == dre_pkg::ROT_CCW) begin
            rot_ev = 1'b1;
            rot_code = dre_pkg::EV_CCW;
            rot_armed = 1'b1;
          end else if (rot == dre_pkg::ROT_CW) begin
            rot_ev = 1'b1;
            rot_code = dre_pkg::EV_CW;
            rot_armed = 1'b1;
          end
        end
        rotation_latched_next = rot_armed & rot[dre_pkg::CODE_B_BIT];
      end
    end
  end

  // Order the events of this poll and flag the last one
  always_comb begin
    slot0.code = btn_ev ? btn_code : rot_code;
    slot0.last = ~(btn_ev & rot_ev);
    slot1.code = rot_code;
    slot1.last = 1'b1;
    n_ev = {1'b0, btn_ev} + {1'b0, rot_ev};
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stable_ticks   <= dre_pkg::STABLE_TICKS_RST;
      events_enabled <= dre_pkg::EVENTS_ENABLED_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        dre_pkg::REG_STABLE_TICKS:   stable_ticks <= cfg_data;
        dre_pkg::REG_EVENTS_ENABLED: events_enabled <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Decoder state, updated on each accepted poll
  always_ff @(posedge clk) begin
    if (rst) begin
      candidate_code   <= '0;
      candidate_since  <= '0;
      accepted_code    <= '0;
      accepted_valid   <= 1'b0;
      button_held      <= 1'b0;
      rotation_latched <= 1'b0;
    end else if (in_xfer) begin
      candidate_code   <= candidate_code_next;
      candidate_since  <= candidate_since_next;
      accepted_code    <= accepted_code_next;
      accepted_valid   <= accepted_valid_next;
      button_held      <= button_held_next;
      rotation_latched <= rotation_latched_next;
    end
  end

  // Result queue pointers and fill count
  always_comb begin
    count_next = count - dre_pkg::QUEUE_CNT_W'(out_xfer);
    if (in_xfer) begin
      count_next = count_next + dre_pkg::QUEUE_CNT_W'(n_ev);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (out_xfer) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (in_xfer) begin
        wr_ptr <= wr_ptr + dre_pkg::QUEUE_PTR_W'(n_ev);
      end
    end
  end

  // Queue storage: payload only, no reset
  always_ff @(posedge clk) begin
    if (in_xfer && n_ev != 2'd0) begin
      queue[wr_ptr] <= slot0;
    end
    if (in_xfer && n_ev == 2'd2) begin
      queue[wr_ptr + 1'b1] <= slot1;
    end
  end

  // Stream handshakes
  assign s_axis_tready = count <= dre_pkg::QUEUE_CNT_W'(dre_pkg::QUEUE_DEPTH - 2);
  assign m_axis_tvalid = count != '0;
  assign m_axis_tdata  = {{(dre_pkg::OUT_DATA_W - 2){1'b0}}, queue[rd_ptr].code};
  assign m_axis_tlast  = queue[rd_ptr].last;

endmodule

// ===== rtl/dre_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the debounced rotary encoder event decoder.
// Depends on dre_pkg; bound to debounced_rotary_encoder_events below.
module dre_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [dre_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tlast
);

  // Nothing is offered on the output right after reset
  a_idle_after_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  // The input only stalls while results are waiting
  a_stall_needs_backlog: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with an empty result queue");

  // A rotation event always closes its poll's run
  a_rotation_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tdata[1:0] == dre_pkg::EV_CW ||
                       m_axis_tdata[1:0] == dre_pkg::EV_CCW)) |-> m_axis_tlast)
    else $error("rotation event not marked last");

  // A stalled output transfer keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled output changed");

endmodule

bind debounced_rotary_encoder_events dre_checker u_dre_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
